// ----- rtl/ppc_pkg.sv -----
// Shared types and codes for the payload protocol classifier.
// No dependencies; the channel interfaces and the top level import it.
package ppc_pkg;

   localparam int PREFIX_BYTES = 20;
   localparam int NAME_LIMIT   = 256;
   localparam logic [15:0] DEPTH_RESET = 16'd1024;

   // Parser phase codes.
   localparam logic [4:0] PH_FIXED     = 5'd0;
   localparam logic [4:0] PH_SIDLEN    = 5'd1;
   localparam logic [4:0] PH_SIDSKIP   = 5'd2;
   localparam logic [4:0] PH_CIPH_HI   = 5'd3;
   localparam logic [4:0] PH_CIPH_LO   = 5'd4;
   localparam logic [4:0] PH_CIPH_SKIP = 5'd5;
   localparam logic [4:0] PH_COMP_LEN  = 5'd6;
   localparam logic [4:0] PH_COMP_SKIP = 5'd7;
   localparam logic [4:0] PH_EXTLEN_HI = 5'd8;
   localparam logic [4:0] PH_EXTLEN_LO = 5'd9;
   localparam logic [4:0] PH_ET_HI     = 5'd10;
   localparam logic [4:0] PH_ET_LO     = 5'd11;
   localparam logic [4:0] PH_EL_HI_O   = 5'd12;
   localparam logic [4:0] PH_EL_LO_O   = 5'd13;
   localparam logic [4:0] PH_EXT_SKIP  = 5'd14;
   localparam logic [4:0] PH_EL_HI_S   = 5'd15;
   localparam logic [4:0] PH_EL_LO_S   = 5'd16;
   localparam logic [4:0] PH_LIST_HI   = 5'd17;
   localparam logic [4:0] PH_LIST_LO   = 5'd18;
   localparam logic [4:0] PH_NAME_TYPE = 5'd19;
   localparam logic [4:0] PH_HN_HI     = 5'd20;
   localparam logic [4:0] PH_HN_LO     = 5'd21;
   localparam logic [4:0] PH_DONE      = 5'd22;
   localparam logic [4:0] PH_FAIL      = 5'd23;

   // Transport kinds.
   localparam logic [1:0] TR_TCP = 2'd1;
   localparam logic [1:0] TR_UDP = 2'd2;

   // Protocol codes.
   localparam logic [4:0] APP_UNKNOWN    = 5'd0;
   localparam logic [4:0] APP_WEB        = 5'd1;
   localparam logic [4:0] APP_WEB_TLS    = 5'd2;
   localparam logic [4:0] APP_NAMESVC    = 5'd3;
   localparam logic [4:0] APP_SSH        = 5'd4;
   localparam logic [4:0] APP_FILEXFER   = 5'd5;
   localparam logic [4:0] APP_SMTP       = 5'd6;
   localparam logic [4:0] APP_MAILBOX    = 5'd7;
   localparam logic [4:0] APP_MAILSYNC   = 5'd8;
   localparam logic [4:0] APP_TELNET     = 5'd9;
   localparam logic [4:0] APP_RDP        = 5'd10;
   localparam logic [4:0] APP_VNC        = 5'd11;
   localparam logic [4:0] APP_SOCKS4     = 5'd12;
   localparam logic [4:0] APP_SOCKS5     = 5'd13;
   localparam logic [4:0] APP_TORRENT    = 5'd14;
   localparam logic [4:0] APP_QUIC       = 5'd15;
   localparam logic [4:0] APP_RTSP       = 5'd16;
   localparam logic [4:0] APP_SIP        = 5'd17;
   localparam logic [4:0] APP_CHAT       = 5'd18;
   localparam logic [4:0] APP_XMPP       = 5'd19;
   localparam logic [4:0] APP_OVPN       = 5'd20;
   localparam logic [4:0] APP_WIREGUARD  = 5'd21;
   localparam logic [4:0] APP_TLS        = 5'd22;

   // Confidence levels.
   localparam logic [2:0] CONF_NONE    = 3'd0;
   localparam logic [2:0] CONF_LOW     = 3'd1;
   localparam logic [2:0] CONF_MEDIUM  = 3'd2;
   localparam logic [2:0] CONF_HIGH    = 3'd3;
   localparam logic [2:0] CONF_CERTAIN = 3'd4;

   // Detection method bits.
   localparam logic [4:0] METH_NONE      = 5'b00000;
   localparam logic [4:0] METH_PORT      = 5'b00001;
   localparam logic [4:0] METH_PATTERN   = 5'b00010;
   localparam logic [4:0] METH_HEURISTIC = 5'b00100;
   localparam logic [4:0] METH_DPI       = 5'b01000;
   localparam logic [4:0] METH_SNI       = 5'b10000;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        last_byte;
      logic        no_payload;
      logic [15:0] dest_port;
      logic [1:0]  transport;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  protocol;
      logic [2:0]  confidence;
      logic [4:0]  methods;
      logic [15:0] tls_version;
   } rsp_word_type;

endpackage

// ----- rtl/ppc_channels_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on ppc_pkg for the word types.
interface ppc_req_if import ppc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppc_rsp_if import ppc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/payload_protocol_classifier_top.sv -----
// The result word of a packet is registered and appears in the cycle after its last word is accepted.
// Throughput: one word per cycle; the parser state and prefix update in one pass per byte.
// A new word is taken whenever the result register is empty or is being read.
// Reset: synchronous, active high; clears the parser, the prefix count, the result
// valid and sets the inspection depth to 1024.
// Depends on ppc_pkg and the interfaces in ppc_channels_if.
module payload_protocol_classifier_top import ppc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ppc_req_if.sink     req_chan,
   ppc_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] depth_ff;
   logic [15:0] count_ff, count_in;
   logic [7:0]  prefix_ff [PREFIX_BYTES];
   logic [7:0]  p [PREFIX_BYTES];
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] skip_ff, skip_in;
   logic [16:0] need_ff, need_in;
   logic [15:0] hold_ff, hold_in;
   logic        sni_ff, sni_in;
   logic [15:0] version_ff, version_in;
   logic        rsp_valid_ff;
   rsp_word_type rsp_ff, rsp_in;

   logic        accept;
   logic        take_byte;
   logic [7:0]  b;
   logic [15:0] w;
   logic [16:0] end_need;
   logic [15:0] idx;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign b         = req_chan.data.payload_byte;
   assign idx       = count_ff;
   assign take_byte = !req_chan.data.no_payload && (count_ff < depth_ff);
   assign w         = {hold_ff[7:0], b};
   assign end_need  = {1'b0, idx} + 17'd1 + {1'b0, w};

   // Per-port default protocol.
   function automatic logic [4:0] port_default(input logic [15:0] port,
                                               input logic [1:0] tr);
      logic [4:0] r;
      r = APP_UNKNOWN;
      if (tr == TR_TCP) begin
         case (port)
            16'd80:    r = APP_WEB;
            16'd443:   r = APP_WEB_TLS;
            16'd22:    r = APP_SSH;
            16'd21:    r = APP_FILEXFER;
            16'd25:    r = APP_SMTP;
            16'd110:   r = APP_MAILBOX;
            16'd143:   r = APP_MAILSYNC;
            16'd23:    r = APP_TELNET;
            16'd3389:  r = APP_RDP;
            16'd5900:  r = APP_VNC;
            16'd1080:  r = APP_SOCKS5;
            16'd554:   r = APP_RTSP;
            16'd5060:  r = APP_SIP;
            16'd6667, 16'd6668, 16'd6669: r = APP_CHAT;
            16'd5222, 16'd5269: r = APP_XMPP;
            16'd1194:  r = APP_OVPN;
            16'd51820: r = APP_WIREGUARD;
            default:   r = APP_UNKNOWN;
         endcase
      end else if (tr == TR_UDP) begin
         case (port)
            16'd53:    r = APP_NAMESVC;
            16'd443:   r = APP_QUIC;
            16'd5060:  r = APP_SIP;
            16'd1194:  r = APP_OVPN;
            16'd51820: r = APP_WIREGUARD;
            default:   r = APP_UNKNOWN;
         endcase
      end
      return r;
   endfunction

   // TLS ClientHello parser: one phase step per inspected byte.
   always_comb begin
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      need_in    = need_ff;
      hold_in    = hold_ff;
      sni_in     = sni_ff;
      version_in = version_ff;
      count_in   = count_ff;
      if (take_byte) begin
         count_in = count_ff + 16'd1;
         case (phase_ff)
            PH_FIXED: begin
               if ((idx == 16'd0 && b != 8'h16) || (idx == 16'd5 && b != 8'h01)) begin
                  phase_in = PH_FAIL;
               end else begin
                  if (idx == 16'd1) version_in = {b, 8'h00};
                  if (idx == 16'd2) version_in = {version_ff[15:8], b};
                  if (idx == 16'd3) hold_in = {8'h00, b};
                  if (idx == 16'd4 && ({1'b0, w} + 17'd5) > need_ff) begin
                     need_in = {1'b0, w} + 17'd5;
                  end
                  if (idx >= 16'd42) phase_in = PH_SIDLEN;
               end
            end
            PH_SIDLEN: begin
               if (b == 8'h00) phase_in = PH_CIPH_HI;
               else begin
                  skip_in  = {8'h00, b};
                  phase_in = PH_SIDSKIP;
               end
            end
            PH_CIPH_HI: begin
               hold_in  = {8'h00, b};
               phase_in = PH_CIPH_LO;
            end
            PH_CIPH_LO: begin
               if (w == 16'd0) phase_in = PH_COMP_LEN;
               else begin
                  skip_in  = w;
                  phase_in = PH_CIPH_SKIP;
               end
            end
            PH_COMP_LEN: begin
               if (b == 8'h00) phase_in = PH_EXTLEN_HI;
               else begin
                  skip_in  = {8'h00, b};
                  phase_in = PH_COMP_SKIP;
               end
            end
            PH_SIDSKIP, PH_CIPH_SKIP, PH_COMP_SKIP, PH_EXT_SKIP: begin
               if (skip_ff <= 16'd1) begin
                  skip_in = 16'd0;
                  case (phase_ff)
                     PH_SIDSKIP:   phase_in = PH_CIPH_HI;
                     PH_CIPH_SKIP: phase_in = PH_COMP_LEN;
                     PH_COMP_SKIP: phase_in = PH_EXTLEN_HI;
                     default:      phase_in = PH_ET_HI;
                  endcase
               end else begin
                  skip_in = skip_ff - 16'd1;
               end
            end
            PH_EXTLEN_HI, PH_ET_HI, PH_EL_HI_O, PH_EL_HI_S, PH_HN_HI: begin
               hold_in  = {8'h00, b};
               phase_in = phase_ff + 5'd1;
            end
            PH_EXTLEN_LO: begin
               if (end_need > need_ff) need_in = end_need;
               phase_in = PH_ET_HI;
            end
            PH_ET_LO: begin
               phase_in = (w == 16'd0) ? PH_EL_HI_S : PH_EL_HI_O;
            end
            PH_EL_LO_O: begin
               if (end_need > need_ff) need_in = end_need;
               if (w == 16'd0) phase_in = PH_ET_HI;
               else begin
                  skip_in  = w;
                  phase_in = PH_EXT_SKIP;
               end
            end
            PH_EL_LO_S: begin
               if (end_need > need_ff) need_in = end_need;
               if (w < 16'd2) phase_in = PH_FAIL;
               else begin
                  hold_in  = w - 16'd2;
                  phase_in = PH_LIST_HI;
               end
            end
            PH_LIST_HI: begin
               skip_in  = {8'h00, b};
               phase_in = PH_LIST_LO;
            end
            PH_LIST_LO: begin
               skip_in  = 16'd0;
               phase_in = ({skip_ff[7:0], b} > hold_ff) ? PH_FAIL : PH_NAME_TYPE;
            end
            PH_NAME_TYPE: begin
               phase_in = (b == 8'h00) ? PH_HN_HI : PH_FAIL;
            end
            PH_HN_LO: begin
               if (w > 16'd0 && w < 16'(NAME_LIMIT)) begin
                  sni_in   = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Prefix view including the byte being accepted.
   always_comb begin
      for (int i = 0; i < PREFIX_BYTES; i++) begin
         p[i] = (take_byte && count_ff == 16'(i)) ? b : prefix_ff[i];
      end
   end

   // Signature checks in priority order, over the updated state.
   always_comb begin
      logic [4:0] dp;
      logic [2:0] dc;
      logic [4:0] db;
      logic       hit;
      logic [31:0] l4;
      logic [15:0] len;
      len = count_in;
      l4  = {p[0], p[1], p[2], p[3]};
      hit = 1'b1;
      dp  = APP_UNKNOWN;
      dc  = CONF_NONE;
      db  = METH_NONE;
      if (sni_in && need_in <= {1'b0, len}) begin
         dp = APP_WEB_TLS; dc = CONF_HIGH; db = METH_SNI;
      end else if (len >= 16'd3 && p[0] == 8'h16 && p[1] == 8'h03) begin
         dp = APP_TLS; dc = CONF_MEDIUM; db = METH_DPI;
      end else if ((len >= 16'd4 && (l4 == "GET " || l4 == "POST" || l4 == "PUT " ||
                    l4 == "HEAD" || l4 == "DELE" || l4 == "OPTI" || l4 == "TRAC" ||
                    l4 == "CONN" || l4 == "PATC")) ||
                   (len >= 16'd8 && {l4, p[4], p[5], p[6]} == "HTTP/1.")) begin
         dp = APP_WEB; dc = CONF_HIGH; db = METH_PATTERN;
      end else if (len >= 16'd4 && l4 == "SSH-") begin
         dp = APP_SSH; dc = CONF_HIGH; db = METH_PATTERN;
      end else if (len >= 16'd12 && p[2][6:3] <= 4'd5) begin
         dp = APP_NAMESVC; dc = CONF_MEDIUM; db = METH_HEURISTIC;
      end else if (len >= 16'd3 && p[0] == 8'h05 && p[1] > 8'd0 && p[1] < 8'd10) begin
         dp = APP_SOCKS5; dc = CONF_HIGH; db = METH_PATTERN;
      end else if (len >= 16'd8 && p[0] == 8'h04 && (p[1] == 8'h01 || p[1] == 8'h02)) begin
         dp = APP_SOCKS4; dc = CONF_HIGH; db = METH_PATTERN;
      end else if (len >= 16'd5 && p[0][7]) begin
         dp = APP_QUIC; dc = CONF_MEDIUM; db = METH_DPI;
      end else if (len >= 16'd20 && p[0] == 8'h13 &&
                   {p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10],
                    p[11], p[12], p[13], p[14], p[15], p[16], p[17], p[18], p[19]}
                   == "BitTorrent protocol") begin
         dp = APP_TORRENT; dc = CONF_CERTAIN; db = METH_PATTERN;
      end else if (len >= 16'd11 && p[0] == 8'h03 && p[1] == 8'h00 && p[5] == 8'he0) begin
         dp = APP_RDP; dc = CONF_HIGH; db = METH_DPI;
      end else if (len >= 16'd12 && l4 == "RFB ") begin
         dp = APP_VNC; dc = CONF_HIGH; db = METH_PATTERN;
      end else begin
         hit = 1'b0;
      end

      rsp_in = '0;
      if (req_chan.data.transport == TR_TCP || req_chan.data.transport == TR_UDP) begin
         rsp_in.protocol = port_default(req_chan.data.dest_port, req_chan.data.transport);
         if (rsp_in.protocol != APP_UNKNOWN) begin
            rsp_in.confidence = CONF_LOW;
            rsp_in.methods    = METH_PORT;
         end
         if (len != 16'd0 && hit) begin
            rsp_in.protocol   = dp;
            rsp_in.confidence = dc;
            rsp_in.methods    = rsp_in.methods | db;
            if (db == METH_SNI) rsp_in.tls_version = version_in;
         end
      end
   end

   // Prefix store: written only while the byte index is inside the prefix.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < PREFIX_BYTES; i++) begin
            prefix_ff[i] <= p[i];
         end
      end
   end

   // Parser state and depth register.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= DEPTH_RESET;
         count_ff   <= '0;
         phase_ff   <= PH_FIXED;
         skip_ff    <= '0;
         need_ff    <= '0;
         hold_ff    <= '0;
         sni_ff     <= 1'b0;
         version_ff <= '0;
      end else begin
         if (csr_write_enable) depth_ff <= csr_write_data;
         if (accept) begin
            if (req_chan.data.last_byte) begin
               count_ff   <= '0;
               phase_ff   <= PH_FIXED;
               skip_ff    <= '0;
               need_ff    <= '0;
               hold_ff    <= '0;
               sni_ff     <= 1'b0;
               version_ff <= '0;
            end else begin
               count_ff   <= count_in;
               phase_ff   <= phase_in;
               skip_ff    <= skip_in;
               need_ff    <= need_in;
               hold_ff    <= hold_in;
               sni_ff     <= sni_in;
               version_ff <= version_in;
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_chan.data.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.data.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
